FILE: hdl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types, codes and widths for the session slot table.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int SLOT_COUNT_DEF = 512;
  localparam int ID_W           = 32;
  localparam int USER_W         = 16;
  localparam int CMD_W          = 2;
  localparam int STATUS_W       = 2;

  // all-ones id marks a free slot
  localparam logic [ID_W-1:0] FREE_ID = '1;

  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     session;
    logic [USER_W-1:0]   user;
  } result_t;

endpackage

FILE: hdl/session_slot_table_top.sv
// ----------------------------------------------------------------------------
// session_slot_table_top
// Fixed table of session slots with create, remove and lookup commands.
//
//   channel   dir  fields (lowest bit first)
//   s_*       in   tuser: command[1:0]; tdata: session_key[31:0], user_handle[47:32]
//   m_*       out  tuser: status[1:0];  tdata: result_session[31:0], result_user[47:32]
//
// a command scans the slots from slot 0 until a hit, then updates the slot and answers;
// a miss or a full table answers once the scan ends, the scan going one slot per cycle
// through the id memory read port and its single comparator
// an unused command or an all-ones key on remove or lookup answers in the next cycle
// after reset every slot of the id memory is cleared to the free marker, no commands taken
// one command at a time; s_tready stays low until the result transaction completes
// ----------------------------------------------------------------------------
module session_slot_table_top import sst_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [47:0]           s_tdata,  // session_key, user_handle
  input  logic [CMD_W-1:0]      s_tuser,  // command
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [47:0]           m_tdata,  // result_session, result_user
  output logic [STATUS_W-1:0]   m_tuser   // status
);

  localparam int AW = $clog2(SLOT_COUNT);

  result_t           res;
  logic              id_we;
  logic [AW-1:0]     id_waddr;
  logic [ID_W-1:0]   id_wdata;
  logic [AW-1:0]     id_raddr;
  logic [ID_W-1:0]   id_rdata;
  logic              user_we;
  logic [AW-1:0]     user_waddr;
  logic [USER_W-1:0] user_wdata;
  logic [AW-1:0]     user_raddr;
  logic [USER_W-1:0] user_rdata;

  sst_ctrl #(.SLOT_COUNT(SLOT_COUNT)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (s_tvalid),
    .cmd_ready  (s_tready),
    .cmd        (s_tuser),
    .key        (s_tdata[31:0]),
    .user       (s_tdata[47:32]),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res),
    .id_we      (id_we),
    .id_waddr   (id_waddr),
    .id_wdata   (id_wdata),
    .id_raddr   (id_raddr),
    .id_rdata   (id_rdata),
    .user_we    (user_we),
    .user_waddr (user_waddr),
    .user_wdata (user_wdata),
    .user_raddr (user_raddr),
    .user_rdata (user_rdata)
  );

  sst_ram #(.WIDTH(ID_W), .DEPTH(SLOT_COUNT)) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (id_waddr),
    .wdata (id_wdata),
    .raddr (id_raddr),
    .rdata (id_rdata)
  );

  sst_ram #(.WIDTH(USER_W), .DEPTH(SLOT_COUNT)) u_user_ram (
    .clk   (clk),
    .we    (user_we),
    .waddr (user_waddr),
    .wdata (user_wdata),
    .raddr (user_raddr),
    .rdata (user_rdata)
  );

  assign m_tdata = {res.user, res.session};
  assign m_tuser = res.status;

endmodule

FILE: hdl/sst_ram.sv
// ----------------------------------------------------------------------------
// sst_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/sst_ctrl.sv
// ----------------------------------------------------------------------------
// sst_ctrl
// Command sequencer: clearing pass, slot scan through one shared id
// comparator, slot update and result register.
// ----------------------------------------------------------------------------
module sst_ctrl import sst_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  localparam int AW = $clog2(SLOT_COUNT)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [ID_W-1:0]     key,
  input  logic [USER_W-1:0]   user,
  output logic                res_valid,
  input  logic                res_ready,
  output result_t             res,
  output logic                id_we,
  output logic [AW-1:0]       id_waddr,
  output logic [ID_W-1:0]     id_wdata,
  output logic [AW-1:0]       id_raddr,
  input  logic [ID_W-1:0]     id_rdata,
  output logic                user_we,
  output logic [AW-1:0]       user_waddr,
  output logic [USER_W-1:0]   user_wdata,
  output logic [AW-1:0]       user_raddr,
  input  logic [USER_W-1:0]   user_rdata
);

  localparam int CW = AW + 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(SLOT_COUNT - 1);
  localparam logic [CW-1:0] SCAN_END  = CW'(SLOT_COUNT);

  state_t            state, state_next;
  logic [CW-1:0]     idx;
  logic              pend;
  logic [AW-1:0]     slot;
  logic [ID_W-1:0]   counter;
  logic [ID_W-1:0]   assigned;
  logic [CMD_W-1:0]  cmd_q;
  logic [ID_W-1:0]   target;
  logic [USER_W-1:0] user_q;
  logic              hit;
  logic              scan_end;
  logic              key_ok;

  // shared comparator: data read last cycle against the search target
  assign hit      = pend && (id_rdata == target);
  assign scan_end = pend && !hit && (idx == SCAN_END);
  assign key_ok   = (key != FREE_ID);
  // counter steps past the free marker before use
  assign assigned = (counter == FREE_ID) ? '0 : counter;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (idx[AW-1:0] == LAST_SLOT) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd == CMD_CREATE ||
              ((cmd == CMD_REMOVE || cmd == CMD_LOOKUP) && key_ok)) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (hit) state_next = S_ACT;
        else if (scan_end) state_next = S_RESP;
      end
      S_ACT: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (res_ready) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_ready  = 1'b0;
    res_valid  = 1'b0;
    id_we      = 1'b0;
    id_waddr   = slot;
    id_wdata   = FREE_ID;
    user_we    = 1'b0;
    case (state)
      S_CLEAR: begin
        id_we    = 1'b1;
        id_waddr = idx[AW-1:0];
      end
      S_IDLE: begin
        cmd_ready = 1'b1;
      end
      S_ACT: begin
        if (cmd_q == CMD_CREATE) begin
          id_we    = 1'b1;
          id_wdata = assigned;
          user_we  = 1'b1;
        end else if (cmd_q == CMD_REMOVE) begin
          id_we = 1'b1;
        end
      end
      S_RESP: begin
        res_valid = 1'b1;
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  assign id_raddr   = idx[AW-1:0];
  assign user_raddr = slot;
  assign user_waddr = slot;
  assign user_wdata = user_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      idx     <= '0;
      pend    <= 1'b0;
      counter <= ID_W'(1);
    end else begin
      state <= state_next;
      case (state)
        S_CLEAR: begin
          idx <= (idx[AW-1:0] == LAST_SLOT) ? '0 : idx + CW'(1);
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_q       <= cmd;
            target      <= (cmd == CMD_CREATE) ? FREE_ID : key;
            user_q      <= user;
            res.status  <= STAT_NOT_FOUND;
            res.session <= FREE_ID;
            res.user    <= '0;
            idx         <= '0;
            pend        <= 1'b0;
          end
        end
        S_SCAN: begin
          if (hit) begin
            pend <= 1'b0;
          end else if (idx != SCAN_END) begin
            pend <= 1'b1;
            slot <= idx[AW-1:0];
            idx  <= idx + CW'(1);
          end else begin
            pend <= 1'b0;
            if (cmd_q == CMD_CREATE) res.status <= STAT_FULL;
          end
        end
        S_ACT: begin
          res.status <= STAT_OK;
          if (cmd_q == CMD_CREATE) begin
            res.session <= assigned;
            counter     <= assigned + ID_W'(1);
          end
          if (cmd_q == CMD_LOOKUP) res.user <= user_rdata;
        end
        default: begin
          pend <= 1'b0;
        end
      endcase
    end
  end

  a_hit_holds_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && hit) |=> (state == S_ACT && $stable(slot)))
    else $error("matched slot not held into update");

  a_counter_never_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACT && cmd_q == CMD_CREATE) |=> (counter != '0))
    else $error("id counter reached zero after create");

  a_full_only_create: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == STAT_FULL) |-> (cmd_q == CMD_CREATE))
    else $error("full status on a non-create command");

  a_create_id_valid: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == STAT_OK && cmd_q == CMD_CREATE)
      |-> (res.session != FREE_ID))
    else $error("create handed out the free marker");

  a_user_only_lookup: assert property (@(posedge clk) disable iff (rst)
    (res_valid && cmd_q != CMD_LOOKUP) |-> (res.user == '0))
    else $error("user handle returned on a non-lookup command");

endmodule

FILE: dv/session_slot_table_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// session_slot_table_top_tb
// Self-checking bench for the session slot table. Commands go in over the
// slave stream and a local table model predicts every response. Each
// response on the master stream is checked field by field. Traffic covers
// directed corner commands, a fill to a full table, long output back-pressure
// and a random mix that drains the table and then refills it.
// ----------------------------------------------------------------------------
module session_slot_table_top_tb;
  import sst_pkg::*;

  localparam int TABLE_SLOTS = SLOT_COUNT_DEF;
  localparam int RANDOM_ITEMS = 600;
  localparam int HOLD_CYCLES = 1500;
  // tuser value with no command behind it
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [47:0]         s_tdata = '0;  // session_key, user_handle
  logic [CMD_W-1:0]    s_tuser = '0;  // command
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [47:0]         m_tdata;       // result_session, result_user
  logic [STATUS_W-1:0] m_tuser;       // status

  always #2 clk = ~clk;

  session_slot_table_top #(.SLOT_COUNT(TABLE_SLOTS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // table model
  logic [ID_W-1:0]   model_ids   [TABLE_SLOTS];
  logic [USER_W-1:0] model_users [TABLE_SLOTS];
  logic [ID_W-1:0]   model_next_id;

  result_t pending_results[$];
  int      fail_count = 0;
  int      burst_left = 0;
  int      hold_req = 0;

  function automatic int first_slot_with(logic [ID_W-1:0] id);
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (model_ids[i] == id) return i;
    end
    return TABLE_SLOTS;
  endfunction

  function automatic result_t table_apply(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] key,
                                          logic [USER_W-1:0] user);
    result_t r;
    int      slot;
    r.status  = STAT_NOT_FOUND;
    r.session = FREE_ID;
    r.user    = '0;
    case (cmd)
      CMD_CREATE: begin
        slot = first_slot_with(FREE_ID);
        if (slot == TABLE_SLOTS) begin
          r.status = STAT_FULL;
        end else begin
          // counter skips the free marker and wraps to zero
          if (model_next_id == FREE_ID) model_next_id = '0;
          r.session = model_next_id;
          model_next_id = model_next_id + 1'b1;
          model_ids[slot] = r.session;
          model_users[slot] = user;
          r.status = STAT_OK;
        end
      end
      CMD_REMOVE: begin
        if (key != FREE_ID) begin
          slot = first_slot_with(key);
          if (slot != TABLE_SLOTS) begin
            model_ids[slot] = FREE_ID;
            model_users[slot] = '0;
            r.status = STAT_OK;
          end
        end
      end
      CMD_LOOKUP: begin
        if (key != FREE_ID) begin
          slot = first_slot_with(key);
          if (slot != TABLE_SLOTS) begin
            r.user = model_users[slot];
            r.status = STAT_OK;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // id of a random occupied slot, or a random key if none turns up
  function automatic logic [ID_W-1:0] pick_live_key();
    int slot;
    for (int tries = 0; tries < 16; tries++) begin
      slot = $urandom_range(0, TABLE_SLOTS - 1);
      if (model_ids[slot] != FREE_ID) return model_ids[slot];
    end
    return $urandom;
  endfunction

  function automatic logic [USER_W-1:0] rand_user();
    return USER_W'($urandom_range(0, 65535));
  endfunction

  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] key,
                          logic [USER_W-1:0] user);
    int gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {user, key};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(table_apply(cmd, key, user));
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 600) : $urandom_range(1, 12);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // receiver: random stretches of ready, random and mostly-stalled patterns,
  // plus a counted hold-off on request
  initial begin : rx_pattern
    int hold_left;
    int run_left;
    int rx_mode;
    hold_left = 0;
    run_left = 0;
    rx_mode = 0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 48);
          rx_mode = $urandom_range(0, 3);
        end
        run_left--;
        case (rx_mode)
          0, 1:    m_tready <= 1'b1;
          2:       m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected response status=%0d session=%h user=%h",
                   $realtime, m_tuser, m_tdata[31:0], m_tdata[47:32]);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.status || m_tdata[31:0] !== want.session ||
            m_tdata[47:32] !== want.user) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: mismatch status exp=%0d got=%0d session exp=%h got=%h user exp=%h got=%h",
                     $realtime, want.status, m_tuser, want.session, m_tdata[31:0],
                     want.user, m_tdata[47:32]);
        end
      end
    end
  end

  task automatic test_directed();
    send_cmd(CMD_LOOKUP, 32'h0000_0000, 16'h1234);
    send_cmd(CMD_REMOVE, FREE_ID, 16'h0000);
    send_cmd(CMD_LOOKUP, FREE_ID, 16'hFFFF);
    send_cmd(CMD_UNUSED, $urandom, rand_user());
    send_cmd(CMD_CREATE, FREE_ID, 16'h0000);
    send_cmd(CMD_CREATE, 32'h0000_0000, 16'hFFFF);
    send_cmd(CMD_CREATE, $urandom, 16'h5A5A);
    send_cmd(CMD_LOOKUP, 32'd1, 16'hFFFF);
    send_cmd(CMD_LOOKUP, 32'd2, 16'h0000);
    send_cmd(CMD_LOOKUP, 32'd3, 16'h0000);
    send_cmd(CMD_LOOKUP, FREE_ID, 16'h0000);
    send_cmd(CMD_REMOVE, FREE_ID, 16'h0000);
    send_cmd(CMD_REMOVE, 32'd2, 16'h0000);
    send_cmd(CMD_LOOKUP, 32'd2, 16'h0000);
    send_cmd(CMD_REMOVE, 32'd2, 16'h0000);
    // freed slot gets reused by the next create
    send_cmd(CMD_CREATE, 32'd0, 16'h8001);
    send_cmd(CMD_LOOKUP, 32'd4, 16'h0000);
    send_cmd(CMD_LOOKUP, 32'hFFFF_FFFE, 16'h0000);
    send_cmd(CMD_LOOKUP, 32'h7FFF_FFFF, 16'h0000);
    send_cmd(CMD_REMOVE, 32'h8000_0000, 16'h0000);
    send_cmd(CMD_UNUSED, 32'd1, 16'hFFFF);
    send_cmd(CMD_LOOKUP, 32'd1, 16'h0000);
  endtask

  task automatic test_fill_and_full();
    logic [ID_W-1:0] top_id;
    while (first_slot_with(FREE_ID) != TABLE_SLOTS)
      send_cmd(CMD_CREATE, $urandom, rand_user());
    repeat (3) send_cmd(CMD_CREATE, $urandom, rand_user());
    // highest slot: longest hit scan
    top_id = model_ids[TABLE_SLOTS - 1];
    send_cmd(CMD_LOOKUP, top_id, rand_user());
    send_cmd(CMD_REMOVE, top_id, rand_user());
    send_cmd(CMD_LOOKUP, top_id, rand_user());
    send_cmd(CMD_CREATE, $urandom, rand_user());
    send_cmd(CMD_CREATE, $urandom, rand_user());
  endtask

  task automatic test_backpressure();
    repeat (2) begin
      hold_req = HOLD_CYCLES;
      send_cmd(CMD_LOOKUP, pick_live_key(), rand_user());
      send_cmd(CMD_REMOVE, pick_live_key(), rand_user());
      send_cmd(CMD_LOOKUP, $urandom, rand_user());
      send_cmd(CMD_CREATE, $urandom, rand_user());
      send_cmd(CMD_LOOKUP, pick_live_key(), rand_user());
    end
  endtask

  task automatic test_random_traffic();
    int               pick;
    bit               grow;
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  key;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // first half drains the table, second half refills it past full
      grow = (n >= RANDOM_ITEMS / 2);
      pick = $urandom_range(0, 99);
      key = pick_live_key();
      if (pick < (grow ? 55 : 20)) begin
        cmd = CMD_CREATE;
        key = $urandom;
      end else if (pick < (grow ? 70 : 65)) begin
        cmd = CMD_REMOVE;
      end else if (pick < 90) begin
        cmd = CMD_LOOKUP;
      end else begin
        case ($urandom_range(0, 3))
          0:       begin cmd = CMD_REMOVE; key = $urandom; end
          1:       begin cmd = CMD_LOOKUP; key = $urandom; end
          2:       begin
            cmd = ($urandom_range(0, 1) == 0) ? CMD_REMOVE : CMD_LOOKUP;
            key = FREE_ID;
          end
          default: begin cmd = CMD_UNUSED; key = $urandom; end
        endcase
      end
      send_cmd(cmd, key, rand_user());
    end
  endtask

  initial begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      model_ids[i] = FREE_ID;
      model_users[i] = '0;
    end
    model_next_id = 32'd1;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_fill_and_full();
    test_backpressure();
    test_random_traffic();

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TABLE_SLOTS + 8) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("PASS session_slot_table_top");
    end else begin
      $display("FAIL session_slot_table_top");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("FAIL session_slot_table_top");
    $finish;
  end

endmodule
